FILE: hw/rtl/assert_macros.svh
// Assertion macros; they expect clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SCSA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("scsa check failed");
`define SCSA_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("scsa check failed");
`else
`define SCSA_ASSERT(lbl, prop)
`define SCSA_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

FILE: hw/rtl/scsa_pkg.sv
package scsa_pkg;

  localparam int POOL_PAGES_MAX = 64;
  localparam int PAGE_BYTES     = 4096;

  localparam int SIZE_W   = 16;
  localparam int OFFSET_W = 18;
  localparam int STATUS_W = 3;
  localparam int POOL_W   = 7;

  localparam int SMALL_BYTES  = 128;
  localparam int MEDIUM_BYTES = 256;
  localparam int LARGE_BYTES  = 512;

  localparam int SMALL_SH  = $clog2(SMALL_BYTES);
  localparam int MEDIUM_SH = $clog2(MEDIUM_BYTES);
  localparam int LARGE_SH  = $clog2(LARGE_BYTES);
  localparam int PAGE_SH   = $clog2(PAGE_BYTES);

  localparam int SMALL_DEPTH  = POOL_PAGES_MAX * PAGE_BYTES / SMALL_BYTES;
  localparam int MEDIUM_DEPTH = POOL_PAGES_MAX * PAGE_BYTES / MEDIUM_BYTES;
  localparam int LARGE_DEPTH  = POOL_PAGES_MAX * PAGE_BYTES / LARGE_BYTES;

  localparam int SMALL_PER  = PAGE_BYTES / SMALL_BYTES;
  localparam int MEDIUM_PER = PAGE_BYTES / MEDIUM_BYTES;
  localparam int LARGE_PER  = PAGE_BYTES / LARGE_BYTES;

  localparam int SLOT_W  = $clog2(SMALL_DEPTH);
  localparam int TOP_W   = $clog2(SMALL_DEPTH + 1);
  localparam int PAGE_W  = $clog2(POOL_PAGES_MAX);
  localparam int CB_W    = $clog2(SMALL_PER);
  localparam int SH_W    = 4;
  localparam int MEM_DEPTH = SMALL_DEPTH + MEDIUM_DEPTH + LARGE_DEPTH;
  localparam int ADDR_W  = $clog2(MEM_DEPTH);

  typedef logic [1:0] cls_t;
  localparam cls_t CLS_SMALL  = 2'd0;
  localparam cls_t CLS_MEDIUM = 2'd1;
  localparam cls_t CLS_LARGE  = 2'd2;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NO_PAGE   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NULL      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    logic [SLOT_W-1:0] wdata;
  } mem_req_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] slot_offset;
    logic [STATUS_W-1:0] status;
  } res_t;

  function automatic logic [SH_W-1:0] cls_shift(cls_t c);
    case (c)
      CLS_SMALL:  return SH_W'(SMALL_SH);
      CLS_MEDIUM: return SH_W'(MEDIUM_SH);
      default:    return SH_W'(LARGE_SH);
    endcase
  endfunction

  function automatic logic [SH_W-1:0] cls_per_shift(cls_t c);
    case (c)
      CLS_SMALL:  return SH_W'(PAGE_SH - SMALL_SH);
      CLS_MEDIUM: return SH_W'(PAGE_SH - MEDIUM_SH);
      default:    return SH_W'(PAGE_SH - LARGE_SH);
    endcase
  endfunction

  function automatic logic [CB_W-1:0] cls_per_m1(cls_t c);
    case (c)
      CLS_SMALL:  return CB_W'(SMALL_PER - 1);
      CLS_MEDIUM: return CB_W'(MEDIUM_PER - 1);
      default:    return CB_W'(LARGE_PER - 1);
    endcase
  endfunction

  function automatic logic [TOP_W-1:0] cls_depth(cls_t c);
    case (c)
      CLS_SMALL:  return TOP_W'(SMALL_DEPTH);
      CLS_MEDIUM: return TOP_W'(MEDIUM_DEPTH);
      default:    return TOP_W'(LARGE_DEPTH);
    endcase
  endfunction

  function automatic logic [ADDR_W-1:0] cls_base(cls_t c);
    case (c)
      CLS_SMALL:  return ADDR_W'(0);
      CLS_MEDIUM: return ADDR_W'(SMALL_DEPTH);
      default:    return ADDR_W'(SMALL_DEPTH + MEDIUM_DEPTH);
    endcase
  endfunction

  function automatic logic [OFFSET_W-1:0] slot_to_offset(logic [SLOT_W-1:0] slot, cls_t c);
    logic [SLOT_W+LARGE_SH-1:0] w;
    w = (SLOT_W + LARGE_SH)'(slot) << cls_shift(c);
    return w[OFFSET_W-1:0];
  endfunction

endpackage

FILE: hw/rtl/scsa_ifs.sv
interface scsa_req_if import scsa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                req_type;
  logic [SIZE_W-1:0]   req_size;
  logic [OFFSET_W-1:0] free_offset;
  logic                free_not_null;

  modport source (output valid, output req_type, output req_size, output free_offset,
                  output free_not_null, input ready);
  modport sink (input valid, input req_type, input req_size, input free_offset,
                input free_not_null, output ready);
endinterface

interface scsa_rsp_if import scsa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OFFSET_W-1:0] slot_offset;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output slot_offset, output status, input ready);
  modport sink (input valid, input slot_offset, input status, output ready);
endinterface

interface scsa_cfg_if import scsa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [POOL_W-1:0] pool_pages;

  modport source (output valid, output pool_pages, input ready);
  modport sink (input valid, input pool_pages, output ready);
endinterface

FILE: hw/rtl/scsa_slot_mem.sv
module scsa_slot_mem import scsa_pkg::*; (
  input  logic              clk,
  input  mem_req_t          mem_req,
  output logic [SLOT_W-1:0] rdata
);

  // All three class stacks share one array: small, then medium, then large.
  logic [SLOT_W-1:0] mem [MEM_DEPTH];

  always_ff @(posedge clk) begin
    if (mem_req.we) begin
      mem[mem_req.addr] <= mem_req.wdata;
    end
    if (mem_req.re) begin
      rdata <= mem[mem_req.addr];
    end
  end

endmodule

FILE: hw/rtl/scsa_seq.sv
`include "assert_macros.svh"

module scsa_seq import scsa_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_type,
  input  logic [SIZE_W-1:0]   in_size,
  input  logic [OFFSET_W-1:0] in_offset,
  input  logic                in_not_null,
  input  logic                cfg_we,
  input  logic [POOL_W-1:0]   cfg_pages,
  output logic                idle,
  output mem_req_t            mem_req,
  input  logic [SLOT_W-1:0]   mem_rdata,
  output logic                res_valid,
  input  logic                res_ready,
  output res_t                res
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;

  logic [1:0] state, state_next;

  logic                req_type;
  logic                too_large;
  logic                not_null;
  cls_t                cls;
  logic [OFFSET_W-1:0] free_off;

  logic [POOL_W-1:0] pool_n;
  logic [POOL_W-1:0] page_top, page_top_next;
  logic [POOL_W-1:0] pool_sat;

  // Per class: stack top, carve bound (entries below it are implied by the
  // last carved page) and that page.
  logic [TOP_W-1:0]  top   [3];
  logic [CB_W-1:0]   cb    [3];
  logic [PAGE_W-1:0] cpage [3];

  logic [TOP_W-1:0]  cur_top, cur_top_next, pop_idx, depth;
  logic [CB_W-1:0]   cur_cb, cur_cb_next, low_slot;
  logic [PAGE_W-1:0] cur_page, cur_page_next, new_page;
  logic [POOL_W-1:0] page_diff;
  logic [SLOT_W-1:0] impl_slot, free_slot;
  logic [PAGE_W+PAGE_SH-1:0] page_bytes;
  logic              implicit;

  assign idle     = (state == S_IDLE) && !rst;
  assign in_ready = idle;
  assign pool_sat = (cfg_pages > POOL_W'(POOL_PAGES_MAX)) ? POOL_W'(POOL_PAGES_MAX) : cfg_pages;

  always_comb begin
    cur_top   = top[cls];
    cur_cb    = cb[cls];
    cur_page  = cpage[cls];
    depth     = cls_depth(cls);
    pop_idx   = cur_top - TOP_W'(1);
    implicit  = (pop_idx < TOP_W'(cur_cb));
    low_slot  = cls_per_m1(cls) - pop_idx[CB_W-1:0];
    impl_slot = (SLOT_W'(cur_page) << cls_per_shift(cls)) | SLOT_W'(low_slot);
    free_slot = SLOT_W'(free_off >> cls_shift(cls)) & SLOT_W'(depth - TOP_W'(1));
    page_diff = pool_n - page_top;
    new_page  = page_diff[PAGE_W-1:0];
    page_bytes = (PAGE_W + PAGE_SH)'(new_page) << PAGE_SH;
  end

  always_comb begin
    state_next    = state;
    page_top_next = page_top;
    cur_top_next  = cur_top;
    cur_cb_next   = cur_cb;
    cur_page_next = cur_page;
    res_valid     = 1'b0;
    res           = '0;
    mem_req       = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (res_ready) begin
          state_next = S_IDLE;
          res_valid  = 1'b1;
          res.status = ST_OK;
          if (too_large) begin
            res.status = ST_TOO_LARGE;
          end else if (req_type == REQ_ALLOC) begin
            if (cur_top != '0) begin
              cur_top_next = pop_idx;
              if (implicit) begin
                res.slot_offset = slot_to_offset(impl_slot, cls);
              end else begin
                // Slot comes from the stack; finish once the read returns.
                res_valid    = 1'b0;
                mem_req.re   = 1'b1;
                mem_req.addr = cls_base(cls) + ADDR_W'(pop_idx);
                state_next   = S_READ;
              end
            end else if (page_top == '0) begin
              res.status = ST_NO_PAGE;
            end else begin
              // Carve: hand out the lowest slot, the rest stay implied.
              page_top_next   = page_top - POOL_W'(1);
              cur_page_next   = new_page;
              cur_cb_next     = cls_per_m1(cls);
              cur_top_next    = TOP_W'(cls_per_m1(cls));
              res.slot_offset = page_bytes[OFFSET_W-1:0];
            end
          end else begin
            if (!not_null) begin
              res.status = ST_NULL;
            end else if (cur_top >= depth) begin
              res.status = ST_FULL;
            end else begin
              mem_req.we    = 1'b1;
              mem_req.addr  = cls_base(cls) + ADDR_W'(cur_top);
              mem_req.wdata = free_slot;
              cur_top_next  = cur_top + TOP_W'(1);
              if (cur_top < TOP_W'(cur_cb)) begin
                cur_cb_next = cur_top[CB_W-1:0];
              end
            end
          end
        end
      end
      S_READ: begin
        if (res_ready) begin
          res_valid       = 1'b1;
          res.status      = ST_OK;
          res.slot_offset = slot_to_offset(mem_rdata, cls);
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      pool_n   <= POOL_W'(POOL_PAGES_MAX);
      page_top <= POOL_W'(POOL_PAGES_MAX);
      for (int i = 0; i < 3; i++) begin
        top[i] <= '0;
        cb[i]  <= '0;
      end
    end else begin
      state <= state_next;
      if (cfg_we && idle) begin
        pool_n   <= pool_sat;
        page_top <= pool_sat;
        for (int i = 0; i < 3; i++) begin
          top[i] <= '0;
          cb[i]  <= '0;
        end
      end else begin
        page_top <= page_top_next;
        if (state == S_EXEC) begin
          top[cls] <= cur_top_next;
          cb[cls]  <= cur_cb_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EXEC) begin
      cpage[cls] <= cur_page_next;
    end
    if (in_valid && in_ready) begin
      req_type  <= in_type;
      too_large <= (in_size > SIZE_W'(LARGE_BYTES));
      not_null  <= in_not_null;
      free_off  <= in_offset;
      if (in_size <= SIZE_W'(SMALL_BYTES)) begin
        cls <= CLS_SMALL;
      end else if (in_size <= SIZE_W'(MEDIUM_BYTES)) begin
        cls <= CLS_MEDIUM;
      end else begin
        cls <= CLS_LARGE;
      end
    end
  end

  `SCSA_ASSERT_ALWAYS(a_rst_idle, rst |=> (state == S_IDLE))
  `SCSA_ASSERT(a_page_top, page_top <= pool_n)
  `SCSA_ASSERT(a_small_top, top[CLS_SMALL] <= TOP_W'(SMALL_DEPTH))
  `SCSA_ASSERT(a_accept_exec, (in_valid && in_ready) |=> (state == S_EXEC))
  `SCSA_ASSERT(a_read_from_exec, (state == S_READ) |-> ($past(state) == S_EXEC || $past(state) == S_READ))

endmodule

FILE: hw/rtl/size_class_slab_allocator_unit.sv
// channel  dir  handshake      payload
// req      in   valid/ready    req_type, req_size, free_offset, free_not_null
// rsp      out  valid/ready    slot_offset, status
// cfg      in   valid/ready    pool_pages
//
// An item passes an accept and an execute state; an allocate that pops a freed
// slot adds a read state for the registered read of the shared slot memory.
// A page carve writes no slots: carved slots are implied by a per-class bound.
// Reset restores a 64-page pool with all class stacks empty, with no sweep.
// A result waits in an output register; the next item is accepted meanwhile
// and stalls in its execute cycle until that register is free.
module size_class_slab_allocator_unit import scsa_pkg::*; (
  input logic        clk,
  input logic        rst,
  scsa_cfg_if.sink   cfg,
  scsa_req_if.sink   req,
  scsa_rsp_if.source rsp
);

  logic              idle;
  mem_req_t          mem_req;
  logic [SLOT_W-1:0] mem_rdata;
  res_t              res;
  logic              res_valid;
  logic              res_ready;
  logic              out_valid;
  res_t              out_res;

  assign cfg.ready = idle;
  assign res_ready = !out_valid || rsp.ready;

  scsa_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (req.valid),
    .in_ready    (req.ready),
    .in_type     (req.req_type),
    .in_size     (req.req_size),
    .in_offset   (req.free_offset),
    .in_not_null (req.free_not_null),
    .cfg_we      (cfg.valid),
    .cfg_pages   (cfg.pool_pages),
    .idle        (idle),
    .mem_req     (mem_req),
    .mem_rdata   (mem_rdata),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  scsa_slot_mem u_mem (
    .clk     (clk),
    .mem_req (mem_req),
    .rdata   (mem_rdata)
  );

  // Hold the result until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res <= res;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.slot_offset = out_res.slot_offset;
  assign rsp.status      = out_res.status;

endmodule
